// ----- design/ssac_pkg.sv -----
// ----------------------------------------------------------------------------
// ssac_pkg
// Shared types and constants for the stream sequence anomaly checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ssac_pkg;

  // Field widths.
  localparam int SRC_W    = 6;
  localparam int SCHEMA_W = 16;
  localparam int SEQ_W    = 32;
  localparam int TIME_W   = 63;
  localparam int LIMIT_W  = 31;
  localparam int AGE_W    = 45;
  localparam int KIND_W   = 3;
  localparam int DATA_W   = 32;
  localparam int PADDR_W  = 4;

  // Nanoseconds to milliseconds: divide by 2^6, then by 15625 (2^6 * 15625 = 10^6).
  localparam int DIV_SHIFT  = 6;
  localparam int REM_W      = 14;
  localparam logic [REM_W:0] DIV_DIVISOR = 15'd15625;
  localparam int DIV_DIGIT  = 4;
  localparam int DIVIDEND_W = 60;
  localparam int DIV_STEPS  = DIVIDEND_W / DIV_DIGIT;
  localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
  localparam int QUO_W      = 44;

  // Event kinds.
  typedef enum logic [KIND_W-1:0] {
    KIND_SCHEMA       = 3'd0,
    KIND_STALE        = 3'd1,
    KIND_FUTURE       = 3'd2,
    KIND_DUPLICATE    = 3'd3,
    KIND_OUT_OF_ORDER = 3'd4,
    KIND_GAP          = 3'd5
  } kind_e;

  // Register word indexes on the configuration port.
  typedef enum logic [1:0] {
    REG_EXPECTED_SCHEMA = 2'd0,
    REG_MAX_AGE         = 2'd1,
    REG_MAX_SKEW        = 2'd2
  } reg_addr_e;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_EVAL,
    ST_EMIT
  } ctrl_state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic accept;
    logic div_step;
    logic eval;
    logic emit;
  } ssac_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic pend_any;
    logic pend_last;
    logic out_free;
  } ssac_stat_t;

endpackage

`default_nettype wire

// ----- design/stream_sequence_anomaly_check.sv -----
// A sample steps through the divide, evaluate and emit states before its first event is valid.
// A new sample is accepted only once the previous one has emitted all its events (or found none);
// the 15-step millisecond divider computes four quotient bits per cycle.
// A clear request completes at intake. Events leave one per cycle through the output
// register unless out_ready_i stalls it. Reset loads the register defaults and marks every
// source unseen at once, with no clearing pass; the stored last sequences are not reset.
// ----------------------------------------------------------------------------
// stream_sequence_anomaly_check
// Per-source sequence gap, duplicate and out-of-order detection with schema and timestamp
// freshness checks on telemetry sample headers.
// ----------------------------------------------------------------------------
`default_nettype none

module stream_sequence_anomaly_check #(
  parameter int NUM_SOURCES = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  // Configuration port.
  input  wire logic                                psel,
  input  wire logic                                penable,
  input  wire logic                                pwrite,
  input  wire logic [ssac_pkg::PADDR_W-1:0]        paddr,
  input  wire logic [ssac_pkg::DATA_W-1:0]         pwdata,
  output logic [ssac_pkg::DATA_W-1:0]              prdata,
  output logic                                     pready,
  // Sample requests.
  input  wire logic                                in_valid_i,
  output logic                                     in_ready_o,
  input  wire logic                                mode_i,
  input  wire logic [ssac_pkg::SRC_W-1:0]          source_index_i,
  input  wire logic [ssac_pkg::SCHEMA_W-1:0]       schema_version_i,
  input  wire logic [ssac_pkg::SEQ_W-1:0]          sequence_req_i,
  input  wire logic [ssac_pkg::TIME_W-1:0]         source_time_ns_i,
  input  wire logic [ssac_pkg::TIME_W-1:0]         now_time_ns_i,
  // Anomaly events.
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ssac_pkg::KIND_W-1:0]              kind_o,
  output logic [ssac_pkg::SRC_W-1:0]               event_source_o,
  output logic [ssac_pkg::SEQ_W-1:0]               event_sequence_o,
  output logic [ssac_pkg::SEQ_W-1:0]               missing_count_o,
  output logic signed [ssac_pkg::AGE_W-1:0]        age_ms_o,
  output logic                                     last_event_o
);

  logic [ssac_pkg::SCHEMA_W-1:0] expected_schema_q;
  logic [ssac_pkg::LIMIT_W-1:0]  max_age_ms_q;
  logic [ssac_pkg::LIMIT_W-1:0]  max_future_skew_ms_q;
  logic                          cfg_wr;
  ssac_pkg::reg_addr_e           cfg_addr;
  ssac_pkg::ssac_cmd_t           cmd;
  ssac_pkg::ssac_stat_t          stat;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_addr = ssac_pkg::reg_addr_e'(paddr[3:2]);

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_schema_q    <= ssac_pkg::SCHEMA_W'(1);
      max_age_ms_q         <= ssac_pkg::LIMIT_W'(1000);
      max_future_skew_ms_q <= ssac_pkg::LIMIT_W'(100);
    end else if (cfg_wr) begin
      case (cfg_addr)
        ssac_pkg::REG_EXPECTED_SCHEMA: expected_schema_q <= pwdata[ssac_pkg::SCHEMA_W-1:0];
        ssac_pkg::REG_MAX_AGE:         max_age_ms_q <= pwdata[ssac_pkg::LIMIT_W-1:0];
        ssac_pkg::REG_MAX_SKEW:        max_future_skew_ms_q <= pwdata[ssac_pkg::LIMIT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (cfg_addr)
      ssac_pkg::REG_EXPECTED_SCHEMA: prdata = ssac_pkg::DATA_W'(expected_schema_q);
      ssac_pkg::REG_MAX_AGE:         prdata = ssac_pkg::DATA_W'(max_age_ms_q);
      ssac_pkg::REG_MAX_SKEW:        prdata = ssac_pkg::DATA_W'(max_future_skew_ms_q);
      default:                       prdata = '0;
    endcase
  end

  // Sequencing controller.
  ssac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (mode_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Datapath.
  ssac_dp #(
    .NUM_SOURCES (NUM_SOURCES)
  ) u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .stat_o               (stat),
    .expected_schema_i    (expected_schema_q),
    .max_age_ms_i         (max_age_ms_q),
    .max_future_skew_ms_i (max_future_skew_ms_q),
    .mode_i               (mode_i),
    .source_index_i       (source_index_i),
    .schema_version_i     (schema_version_i),
    .sequence_req_i       (sequence_req_i),
    .source_time_ns_i     (source_time_ns_i),
    .now_time_ns_i        (now_time_ns_i),
    .out_valid_o          (out_valid_o),
    .out_ready_i          (out_ready_i),
    .kind_o               (kind_o),
    .event_source_o       (event_source_o),
    .event_sequence_o     (event_sequence_o),
    .missing_count_o      (missing_count_o),
    .age_ms_o             (age_ms_o),
    .last_event_o         (last_event_o)
  );

endmodule

`default_nettype wire

// ----- design/ssac_ctrl.sv -----
// ----------------------------------------------------------------------------
// ssac_ctrl
// Sequencing state machine: request intake, divider steps, evaluation and
// one event per cycle toward the output register while it is free.
// ----------------------------------------------------------------------------
`default_nettype none

module ssac_ctrl (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 in_valid_i,
  input  wire logic                 mode_i,
  output logic                      in_ready_o,
  input  wire ssac_pkg::ssac_stat_t stat_i,
  output ssac_pkg::ssac_cmd_t       cmd_o
);

  ssac_pkg::ctrl_state_e             state_q, state_d;
  logic [ssac_pkg::DIV_CNT_W-1:0]    cnt_q, cnt_d;

  // State and step counter registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ssac_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

  // Next state and commands.
  always_comb begin
    state_d    = state_q;
    cnt_d      = cnt_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      ssac_pkg::ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
        // A clear request finishes in the accept cycle.
        if (in_valid_i && !mode_i) begin
          state_d = ssac_pkg::ST_DIVIDE;
          cnt_d   = '0;
        end
      end
      ssac_pkg::ST_DIVIDE: begin
        cmd_o.div_step = 1'b1;
        if (cnt_q == ssac_pkg::DIV_CNT_W'(ssac_pkg::DIV_STEPS - 1)) begin
          state_d = ssac_pkg::ST_EVAL;
        end else begin
          cnt_d = cnt_q + 1'b1;
        end
      end
      ssac_pkg::ST_EVAL: begin
        cmd_o.eval = 1'b1;
        state_d    = ssac_pkg::ST_EMIT;
      end
      ssac_pkg::ST_EMIT: begin
        if (!stat_i.pend_any) begin
          state_d = ssac_pkg::ST_IDLE;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          if (stat_i.pend_last) begin
            state_d = ssac_pkg::ST_IDLE;
          end
        end
      end
      default: begin
        state_d = ssac_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

// ----- design/ssac_dp.sv -----
// ----------------------------------------------------------------------------
// ssac_dp
// Datapath: sample capture, nanosecond-to-millisecond divider, per-source
// sequence table, event evaluation and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssac_dp #(
  parameter int NUM_SOURCES = 64
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire ssac_pkg::ssac_cmd_t                 cmd_i,
  output ssac_pkg::ssac_stat_t                     stat_o,
  input  wire logic [ssac_pkg::SCHEMA_W-1:0]       expected_schema_i,
  input  wire logic [ssac_pkg::LIMIT_W-1:0]        max_age_ms_i,
  input  wire logic [ssac_pkg::LIMIT_W-1:0]        max_future_skew_ms_i,
  input  wire logic                                mode_i,
  input  wire logic [ssac_pkg::SRC_W-1:0]          source_index_i,
  input  wire logic [ssac_pkg::SCHEMA_W-1:0]       schema_version_i,
  input  wire logic [ssac_pkg::SEQ_W-1:0]          sequence_req_i,
  input  wire logic [ssac_pkg::TIME_W-1:0]         source_time_ns_i,
  input  wire logic [ssac_pkg::TIME_W-1:0]         now_time_ns_i,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic [ssac_pkg::KIND_W-1:0]              kind_o,
  output logic [ssac_pkg::SRC_W-1:0]               event_source_o,
  output logic [ssac_pkg::SEQ_W-1:0]               event_sequence_o,
  output logic [ssac_pkg::SEQ_W-1:0]               missing_count_o,
  output logic signed [ssac_pkg::AGE_W-1:0]        age_ms_o,
  output logic                                     last_event_o
);

  // Only indexes below 64 are reachable through the source field.
  localparam int Depth = (NUM_SOURCES < 64) ? NUM_SOURCES : 64;
  localparam int IdxW  = (Depth > 1) ? $clog2(Depth) : 1;

  // Request capture.
  logic [ssac_pkg::SRC_W-1:0]      src_q;
  logic [ssac_pkg::SEQ_W-1:0]      seq_q;
  logic [IdxW-1:0]                 idx_q;
  logic                            in_table_q;
  logic                            schema_mis_q;
  logic                            neg_q;
  logic [IdxW-1:0]                 idx_in;
  logic                            in_table_in;
  logic                            neg_in;
  logic [ssac_pkg::TIME_W-1:0]     fwd_diff;
  logic [ssac_pkg::TIME_W-1:0]     rev_diff;
  logic [ssac_pkg::TIME_W-1:0]     mag_in;

  // Divider.
  logic [ssac_pkg::REM_W-1:0]      rem_q, rem_v;
  logic [ssac_pkg::DIVIDEND_W-1:0] sh_q, sh_v;
  logic [ssac_pkg::REM_W:0]        trial;

  // Sequence table.
  logic [Depth-1:0]                seen_q;
  logic [ssac_pkg::SEQ_W-1:0]      last_seq_mem [Depth];
  logic [ssac_pkg::SEQ_W-1:0]      last_rd_q;
  logic                            seen_rd_q;
  logic                            tbl_we;

  // Evaluation.
  logic [ssac_pkg::QUO_W-1:0]      quo;
  logic [ssac_pkg::AGE_W-1:0]      age_mag;
  logic                            stale;
  logic                            future;
  logic                            seq_dup;
  logic                            seq_lt;
  logic                            seq_gap;
  logic [ssac_pkg::SEQ_W-1:0]      seq_missing;
  logic                            seq_chk;
  logic signed [ssac_pkg::AGE_W-1:0] age_q;
  logic [ssac_pkg::SEQ_W-1:0]      miss_q;
  ssac_pkg::kind_e                 age_kind_q;
  ssac_pkg::kind_e                 seq_kind_q;
  logic [2:0]                      pend_q;
  logic [2:0]                      pend_after;

  // Output register.
  logic                            out_valid_q;
  ssac_pkg::kind_e                 kind_q;
  logic [ssac_pkg::SEQ_W-1:0]      miss_out_q;
  logic signed [ssac_pkg::AGE_W-1:0] age_out_q;
  logic                            last_q;
  logic [ssac_pkg::SRC_W-1:0]      src_out_q;
  logic [ssac_pkg::SEQ_W-1:0]      seq_out_q;
  ssac_pkg::kind_e                 ev_kind;
  logic [ssac_pkg::SEQ_W-1:0]      ev_miss;
  logic signed [ssac_pkg::AGE_W-1:0] ev_age;

  // Table index and absolute time difference of the incoming request.
  assign idx_in      = source_index_i[IdxW-1:0];
  assign in_table_in = (32'(source_index_i) < 32'(NUM_SOURCES));
  assign neg_in      = (now_time_ns_i < source_time_ns_i);
  assign fwd_diff    = now_time_ns_i - source_time_ns_i;
  assign rev_diff    = source_time_ns_i - now_time_ns_i;
  assign mag_in      = neg_in ? rev_diff : fwd_diff;

  // Captured request fields and divider registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      src_q        <= source_index_i;
      seq_q        <= sequence_req_i;
      idx_q        <= idx_in;
      in_table_q   <= in_table_in;
      schema_mis_q <= (schema_version_i != expected_schema_i);
      neg_q        <= neg_in;
      rem_q        <= '0;
      sh_q         <= ssac_pkg::DIVIDEND_W'(mag_in[ssac_pkg::TIME_W-1:ssac_pkg::DIV_SHIFT]);
    end else if (cmd_i.div_step) begin
      rem_q <= rem_v;
      sh_q  <= sh_v;
    end
  end

  // Restoring division by 15625, four quotient bits per step.
  always_comb begin
    rem_v = rem_q;
    sh_v  = sh_q;
    trial = '0;
    for (int k = 0; k < ssac_pkg::DIV_DIGIT; k++) begin
      trial = {rem_v, sh_v[ssac_pkg::DIVIDEND_W-1]};
      sh_v  = {sh_v[ssac_pkg::DIVIDEND_W-2:0], 1'b0};
      if (trial >= ssac_pkg::DIV_DIVISOR) begin
        rem_v   = ssac_pkg::REM_W'(trial - ssac_pkg::DIV_DIVISOR);
        sh_v[0] = 1'b1;
      end else begin
        rem_v = trial[ssac_pkg::REM_W-1:0];
      end
    end
  end

  // Seen flags: cleared at reset and by clear requests, set on table update.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seen_q    <= '0;
      seen_rd_q <= 1'b0;
    end else begin
      if (cmd_i.accept) begin
        seen_rd_q <= in_table_in & seen_q[idx_in];
        if (mode_i && in_table_in) begin
          seen_q[idx_in] <= 1'b0;
        end
      end
      if (tbl_we) begin
        seen_q[idx_q] <= 1'b1;
      end
    end
  end

  // Last sequence memory, registered read at request intake.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      last_seq_mem[idx_q] <= seq_q;
    end
    if (cmd_i.accept) begin
      last_rd_q <= last_seq_mem[idx_in];
    end
  end

  // Age and sequence checks.
  assign quo         = sh_q[ssac_pkg::QUO_W-1:0];
  assign age_mag     = {1'b0, quo};
  assign stale       = !neg_q && (quo > ssac_pkg::QUO_W'(max_age_ms_i));
  assign future      = neg_q && (quo > ssac_pkg::QUO_W'(max_future_skew_ms_i));
  assign seq_dup     = (seq_q == last_rd_q);
  assign seq_lt      = (seq_q < last_rd_q);
  assign seq_missing = seq_q + ~last_rd_q;
  assign seq_gap     = !seq_dup && !seq_lt && (seq_missing != '0);
  assign seq_chk     = in_table_q && seen_rd_q;
  assign tbl_we      = cmd_i.eval && in_table_q && (!seen_rd_q || (!seq_dup && !seq_lt));

  // Evaluation results.
  always_ff @(posedge clk_i) begin
    if (cmd_i.eval) begin
      age_q      <= neg_q ? $signed(-age_mag) : $signed(age_mag);
      miss_q     <= seq_gap ? seq_missing : '0;
      age_kind_q <= stale ? ssac_pkg::KIND_STALE : ssac_pkg::KIND_FUTURE;
      seq_kind_q <= seq_dup ? ssac_pkg::KIND_DUPLICATE :
                    (seq_lt ? ssac_pkg::KIND_OUT_OF_ORDER : ssac_pkg::KIND_GAP);
    end
  end

  // Pending events, lowest bit goes first.
  assign pend_after = pend_q & (pend_q - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (cmd_i.eval) begin
      pend_q <= {seq_chk && (seq_dup || seq_lt || seq_gap), stale || future, schema_mis_q};
    end else if (cmd_i.emit) begin
      pend_q <= pend_after;
    end
  end

  // Fields of the next event to leave.
  always_comb begin
    if (pend_q[0]) begin
      ev_kind = ssac_pkg::KIND_SCHEMA;
      ev_miss = '0;
      ev_age  = '0;
    end else if (pend_q[1]) begin
      ev_kind = age_kind_q;
      ev_miss = '0;
      ev_age  = age_q;
    end else begin
      ev_kind = seq_kind_q;
      ev_miss = miss_q;
      ev_age  = age_q;
    end
  end

  // Output register valid.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload.
  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      kind_q     <= ev_kind;
      miss_out_q <= ev_miss;
      age_out_q  <= ev_age;
      last_q     <= (pend_after == '0);
      src_out_q  <= src_q;
      seq_out_q  <= seq_q;
    end
  end

  assign stat_o.pend_any  = (pend_q != '0);
  assign stat_o.pend_last = (pend_q != '0) && (pend_after == '0);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  assign out_valid_o      = out_valid_q;
  assign kind_o           = kind_q;
  assign event_source_o   = src_out_q;
  assign event_sequence_o = seq_out_q;
  assign missing_count_o  = miss_out_q;
  assign age_ms_o         = age_out_q;
  assign last_event_o     = last_q;

endmodule

`default_nettype wire
